[rtl/core/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants of the circular deque
// Operation and status codes, field widths and the cell command set.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 2;
  localparam int unsigned StW   = 2;
  localparam int unsigned OccW  = 5;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_PUSH_BACK  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // What every cell of a chain does at a clock edge.
  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_SHR   = 2'd1,
    CMD_SHL   = 2'd2,
    CMD_LOAD  = 2'd3
  } cmd_e;

endpackage

[rtl/core/cdq_cell.sv]
// ----------------------------------------------------------------------------
// cdq_cell: one storage cell of a deque chain
// Holds one word; takes its left or right neighbor's word on a shift, or the
// broadcast word when a load targets its own position.
// ----------------------------------------------------------------------------
module cdq_cell
  import cdq_pkg::*;
#(
  parameter int unsigned CntW  = 5,
  parameter int unsigned Index = 0
) (
  input  logic             clk_i,
  input  cmd_e             cmd_i,
  input  logic [CntW-1:0]  cnt_i,
  input  logic [DataW-1:0] load_i,
  input  logic [DataW-1:0] left_i,
  input  logic [DataW-1:0] right_i,
  output logic [DataW-1:0] word_o
);

  logic [DataW-1:0] word_d, word_q;

  always_comb begin
    word_d = word_q;
    case (cmd_i)
      CMD_SHR:  word_d = left_i;
      CMD_SHL:  word_d = right_i;
      CMD_LOAD: begin
        if (cnt_i == CntW'(Index)) begin
          word_d = load_i;
        end
      end
      default:  word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

[rtl/core/cdq_chain.sv]
// ----------------------------------------------------------------------------
// cdq_chain: row of cells holding the deque in order from one end
// Cell 0 is the near end. A shift right inserts at cell 0, a shift left
// removes cell 0, and a load writes the cell just past the last held word.
// ----------------------------------------------------------------------------
module cdq_chain
  import cdq_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned CntW  = 5
) (
  input  logic             clk_i,
  input  cmd_e             cmd_i,
  input  logic [CntW-1:0]  cnt_i,
  input  logic [DataW-1:0] data_i,
  output logic [DataW-1:0] head_o
);

  logic [DataW-1:0] word_w [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [DataW-1:0] left_w, right_w;

    if (i == 0) begin : g_first
      assign left_w = data_i;
    end else begin : g_mid_l
      assign left_w = word_w[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_w = word_w[i];
    end else begin : g_mid_r
      assign right_w = word_w[i+1];
    end

    cdq_cell #(
      .CntW  (CntW),
      .Index (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd_i),
      .cnt_i   (cnt_i),
      .load_i  (data_i),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (word_w[i])
    );
  end

  assign head_o = word_w[0];

endmodule

[rtl/core/circular_deque_unit.sv]
// ----------------------------------------------------------------------------
// circular_deque_unit: double-ended queue of signed 32-bit words
// Two mirrored cell chains hold the contents, one ordered from the front and
// one from the back, so both ends are always at a fixed cell.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                              | tuser
//  s_axis   | in  | [31:0] data_in                     | [1:0] func
//  m_axis   | out | [31:0] data_out, [36:32] occupancy | [1:0] status
//
// The chains, the count and the output register all update at the edge that
// accepts an item. A new item is accepted while the previous result is
// being taken, so the unit sustains one item per cycle as long as results
// are taken. s_axis_tready_o drops only while a result sits unclaimed.
// Reset clears the count and the output valid; the cell contents are not
// reset and are never read before written.
// ----------------------------------------------------------------------------
module circular_deque_unit
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] data_in
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] data_out, [36:32] occupancy
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic             accept_w;
  op_e              op_w;
  logic             full_w, empty_w;
  cmd_e             front_cmd_w, back_cmd_w;
  logic [DataW-1:0] front_head_w, back_head_w;

  logic [CntW-1:0]  cnt_d, cnt_q;
  logic             out_valid_d, out_valid_q;
  logic [DataW-1:0] out_data_d, out_data_q;
  status_e          out_status_d, out_status_q;
  logic [OccW-1:0]  out_occ_d, out_occ_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept_w        = s_axis_tvalid_i && s_axis_tready_o;
  assign op_w            = op_e'(s_axis_tuser_i);
  assign full_w          = (cnt_q == CntW'(DEPTH));
  assign empty_w         = (cnt_q == '0);

  always_comb begin
    front_cmd_w  = CMD_HOLD;
    back_cmd_w   = CMD_HOLD;
    cnt_d        = cnt_q;
    out_data_d   = '0;
    out_status_d = ST_DONE;
    case (op_w)
      OP_PUSH_FRONT: begin
        if (full_w) begin
          out_status_d = ST_FULL;
        end else begin
          front_cmd_w = CMD_SHR;
          back_cmd_w  = CMD_LOAD;
          cnt_d       = cnt_q + CntW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full_w) begin
          out_status_d = ST_FULL;
        end else begin
          front_cmd_w = CMD_LOAD;
          back_cmd_w  = CMD_SHR;
          cnt_d       = cnt_q + CntW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty_w) begin
          out_status_d = ST_EMPTY;
        end else begin
          front_cmd_w = CMD_SHL;
          out_data_d  = front_head_w;
          cnt_d       = cnt_q - CntW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty_w) begin
          out_status_d = ST_EMPTY;
        end else begin
          back_cmd_w = CMD_SHL;
          out_data_d = back_head_w;
          cnt_d      = cnt_q - CntW'(1);
        end
      end
      default: begin
        out_status_d = ST_DONE;
      end
    endcase

    // Without an accepted item the chains and the count stand still.
    if (!accept_w) begin
      front_cmd_w = CMD_HOLD;
      back_cmd_w  = CMD_HOLD;
      cnt_d       = cnt_q;
    end
  end

  assign out_occ_d   = OccW'(cnt_d);
  assign out_valid_d = accept_w || (out_valid_q && !m_axis_tready_i);

  // The front chain keeps the front word in cell 0, the back chain the back word.
  cdq_chain #(
    .Depth (DEPTH),
    .CntW  (CntW)
  ) u_front_chain (
    .clk_i  (clk_i),
    .cmd_i  (front_cmd_w),
    .cnt_i  (cnt_q),
    .data_i (s_axis_tdata_i),
    .head_o (front_head_w)
  );

  cdq_chain #(
    .Depth (DEPTH),
    .CntW  (CntW)
  ) u_back_chain (
    .clk_i  (clk_i),
    .cmd_i  (back_cmd_w),
    .cnt_i  (cnt_q),
    .data_i (s_axis_tdata_i),
    .head_o (back_head_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
      out_occ_q    <= out_occ_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_occ_q, out_data_q};
  assign m_axis_tuser_o  = out_status_q;

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of circular_deque_unit
// A directed opening covers empty and full refusals, index wrap and extreme
// words, then about 1100 random operations run in phases with random idling,
// one stretch with no idling and one long back-pressure hold. A scoreboard
// predicts every result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import cdq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth      = 16;
  localparam int QuietLimit = 2000;
  localparam int StallLen   = 60;

  typedef struct packed {
    op_e         func;
    logic [31:0] word;
  } deque_cmd_t;

  typedef struct packed {
    logic [31:0] word;
    status_e     st;
    logic [4:0]  occ;
  } deque_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;   // [31:0] data_in
  logic [1:0]  s_axis_tuser_i = '0;   // [1:0] func
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;        // [31:0] data_out, [36:32] occupancy
  logic [1:0]  m_axis_tuser_o;        // [1:0] status

  circular_deque_unit #(
    .DEPTH(Depth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  deque_cmd_t    op_pending_q[$];
  deque_result_t result_due_q[$];
  int            error_cnt = 0;
  int            send_idle_pct = 38;
  int            recv_idle_pct = 38;
  int            hold_order = 0;
  int            hold_seen = 0;
  int            hold_left = 0;
  int            quiet_cycles = 0;
  logic          in_taken = 1'b0;
  deque_cmd_t    drv_item;

  // Shadow copy of the deque. Depth is a power of two, so the 4-bit indexes
  // wrap by themselves in both directions.
  logic [31:0] shadow_slots [Depth];
  logic [3:0]  shadow_head = '0;
  logic [3:0]  shadow_tail = '0;
  logic [4:0]  shadow_count = '0;

  function automatic deque_result_t deque_apply(input deque_cmd_t cmd);
    deque_result_t r;
    r.word = '0;
    r.st   = ST_DONE;
    case (cmd.func)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count == Depth) begin
          r.st = ST_FULL;
        end else if (cmd.func == OP_PUSH_FRONT) begin
          shadow_head = shadow_head - 4'd1;
          shadow_slots[shadow_head] = cmd.word;
          shadow_count = shadow_count + 5'd1;
        end else begin
          shadow_slots[shadow_tail] = cmd.word;
          shadow_tail = shadow_tail + 4'd1;
          shadow_count = shadow_count + 5'd1;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          r.st = ST_EMPTY;
        end else if (cmd.func == OP_POP_FRONT) begin
          r.word = shadow_slots[shadow_head];
          shadow_head = shadow_head + 4'd1;
          shadow_count = shadow_count - 5'd1;
        end else begin
          shadow_tail = shadow_tail - 4'd1;
          r.word = shadow_slots[shadow_tail];
          shadow_count = shadow_count - 5'd1;
        end
      end
    endcase
    r.occ = shadow_count;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t ns: %s mismatch, expected %h, got %h", $realtime, what, want, got);
    error_cnt++;
  endtask

  task automatic add_op(input op_e f, input logic [31:0] w);
    deque_cmd_t c;
    c.func = f;
    c.word = w;
    op_pending_q.push_back(c);
  endtask

  task automatic add_random_ops(input int count);
    int push_pct;
    logic [31:0] w;
    push_pct = 50;
    for (int i = 0; i < count; i++) begin
      // Bias changes every few dozen items so the deque swings between
      // empty and full instead of hovering around half.
      if (i % 40 == 0) begin
        case ($urandom_range(2, 0))
          0: push_pct = 15;
          1: push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      case ($urandom_range(7, 0))
        0: w = 32'h7fff_ffff;
        1: w = 32'h8000_0000;
        2: w = ($urandom_range(1, 0) != 0) ? 32'hffff_ffff : 32'h0;
        default: w = $urandom();
      endcase
      if ($urandom_range(99, 0) < push_pct) begin
        add_op(($urandom_range(1, 0) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, w);
      end else begin
        add_op(($urandom_range(1, 0) != 0) ? OP_POP_FRONT : OP_POP_BACK, w);
      end
    end
  endtask

  // Checked at the rising edge, where the sender's queue and its valid
  // always agree.
  task automatic drain;
    while (op_pending_q.size() != 0 || s_axis_tvalid_i || result_due_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Sender: holds an offered item until it is taken, otherwise picks the
  // next one or idles.
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid_i && !in_taken)) begin
      if (op_pending_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        drv_item = op_pending_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= drv_item.word;
        s_axis_tuser_i  <= drv_item.func;
      end else begin
        s_axis_tvalid_i <= 1'b0;
        s_axis_tdata_i  <= $urandom();
        s_axis_tuser_i  <= 2'($urandom());
      end
    end
  end

  // Receiver: random ready, plus a long hold whenever one is requested.
  always @(negedge clk_i) begin
    if (hold_order != hold_seen) begin
      hold_seen = hold_order;
      hold_left = StallLen;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Results are checked before the item accepted at the same edge is
  // predicted, since that item's result cannot appear before the next edge.
  always @(posedge clk_i) begin
    deque_result_t want;
    deque_cmd_t    cmd;
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (result_due_q.size() == 0) begin
          report_mismatch("unexpected result", '0, m_axis_tdata_o[31:0]);
        end else begin
          want = result_due_q.pop_front();
          if (m_axis_tdata_o[31:0] !== want.word)
            report_mismatch("data_out", want.word, m_axis_tdata_o[31:0]);
          if (m_axis_tuser_o !== want.st)
            report_mismatch("status", 32'(want.st), 32'(m_axis_tuser_o));
          if (m_axis_tdata_o[36:32] !== want.occ)
            report_mismatch("occupancy", 32'(want.occ), 32'(m_axis_tdata_o[36:32]));
        end
      end
      in_taken = s_axis_tvalid_i && s_axis_tready_o;
      if (in_taken) begin
        cmd.func = op_e'(s_axis_tuser_i);
        cmd.word = s_axis_tdata_i;
        result_due_q.push_back(deque_apply(cmd));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("circular_deque_unit test failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Refused pops on an empty deque, a fill to full from both ends with the
    // front index wrapping below zero, refused pushes, then a pop at each end.
    add_op(OP_POP_FRONT, 32'hffff_ffff);
    add_op(OP_POP_BACK, 32'h0);
    add_op(OP_PUSH_FRONT, 32'h7fff_ffff);
    add_op(OP_PUSH_BACK, 32'h8000_0000);
    add_op(OP_PUSH_FRONT, 32'hffff_ffff);
    add_op(OP_PUSH_BACK, 32'h0);
    add_op(OP_PUSH_FRONT, 32'h5555_5555);
    add_op(OP_PUSH_BACK, 32'haaaa_aaaa);
    for (int i = 0; i < 10; i++) begin
      add_op((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom());
    end
    add_op(OP_PUSH_FRONT, 32'h1234_5678);
    add_op(OP_PUSH_BACK, 32'h8765_4321);
    add_op(OP_POP_FRONT, 32'h0);
    add_op(OP_POP_BACK, 32'h0);
    drain();

    add_random_ops(400);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_ops(300);
    drain();

    send_idle_pct = 38;
    recv_idle_pct = 38;
    add_random_ops(400);
    hold_order++;
    drain();

    repeat (8) @(negedge clk_i);
    if (error_cnt == 0) begin
      $display("circular_deque_unit test passed");
    end else begin
      $display("circular_deque_unit test failed");
    end
    $finish;
  end

endmodule
